// ===== hw/rtl/sfrc_pkg.sv =====
// Shared types and constants for the serial frame receiver and checker.
package sfrc_pkg;

  // Request codes carried in req_type
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Frame framing constants
  localparam logic [7:0] PREAMBLE_BYTE = 8'h5A;
  localparam logic [7:0] POST_FIRST    = 8'h0D;
  localparam logic [7:0] POST_SECOND   = 8'h0A;
  localparam logic [8:0] OVERHEAD      = 9'd3;
  localparam logic [7:0] MIN_LENGTH    = 8'd5;
  localparam logic [7:0] LEN_ONE_VALUE = 8'd6;
  localparam logic [7:0] LEN_TWO_VALUE = 8'd7;

  // Configuration register index (byte address 8*i)
  localparam logic REG_VALID_KEY_MASK = 1'b0;
  localparam logic [63:0] KEY_MASK_RESET = '1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        frame_complete;
    logic        frame_valid;
    logic [7:0]  key_code;
    logic [15:0] value_word;
    logic [1:0]  value_bytes;
  } out_item_t;

  // Per-frame receiver state
  typedef struct packed {
    logic [8:0]  byte_count;
    logic [7:0]  frame_length;
    logic [7:0]  running_sum;
    logic [7:0]  key_byte;
    logic [15:0] value_bytes_held;
    logic [7:0]  received_checksum;
    logic [15:0] tail_bytes;
  } frame_state_t;

endpackage

// ===== hw/rtl/serial_frame_receiver_checker_top.sv =====
// Top level of the serial frame receiver and checker.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  in_item  (req_type, rx_byte)
//   out_*        out   out_valid/out_stall out_item (accepted ... value_bytes)
//   APB          in    psel/penable/pready valid_key_mask at byte address 0
//
// One item per cycle sustained while the output is not stalled; each item passes
// through the input register and then into the result register.
// The frame state updates as the item moves into the result register.
// A stall on the output holds both stages and backs up into in_stall.
// Synchronous active-high reset clears the frame state and sets the key mask
// to all ones; no clearing pass is needed.
module serial_frame_receiver_checker_top #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sfrc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sfrc_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import sfrc_pkg::*;

  logic        key_mask_wr;
  logic [63:0] key_mask;

  logic        hold_valid;
  in_item_t    hold_item;
  logic        advance;
  logic        step;
  out_item_t   step_result;

  // Configuration register
  assign pready      = 1'b1;
  assign key_mask_wr = psel && penable && pwrite && (paddr[3] == REG_VALID_KEY_MASK);
  assign prdata      = (paddr[3] == REG_VALID_KEY_MASK) ? key_mask : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask <= KEY_MASK_RESET;
    end else if (key_mask_wr) begin
      key_mask <= pwdata;
    end
  end

  // Pipeline control: result register frees when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  sfrc_frame #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (hold_item),
    .key_mask (key_mask),
    .result   (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= step_result;
    end
  end

endmodule

// ===== hw/rtl/sfrc_frame.sv =====
// Frame state registers and the per-item update and check logic.
module sfrc_frame #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sfrc_pkg::in_item_t item,
  input  logic [63:0]       key_mask,
  output sfrc_pkg::out_item_t result
);
  import sfrc_pkg::*;

  frame_state_t state;
  frame_state_t state_next;

  logic [8:0] pos;
  logic [8:0] eff_len;
  logic       cur_complete;
  logic       refuse;
  logic       store;
  logic [7:0] b;
  logic [7:0] len_new;
  logic [8:0] eff_len_n;
  logic       complete_n;
  logic       key_ok_n;
  logic       valid_n;

  assign pos = state.byte_count;
  assign b   = item.rx_byte;

  // Decide whether this byte is refused against the current state
  always_comb begin
    eff_len      = (pos > 9'd2) ? {1'b0, state.frame_length} : 9'd0;
    cur_complete = (pos == eff_len + OVERHEAD);
    refuse       = (pos >= 9'(BUFFER_DEPTH)) || cur_complete ||
                   ((pos < 9'd2) && (b != PREAMBLE_BYTE));
    store        = (item.req_type == REQ_DATA) && !refuse;
  end

  // Build the state after this item
  always_comb begin
    state_next = state;
    len_new    = (pos == 9'd2) ? b : state.frame_length;
    if (item.req_type == REQ_CLEAR) begin
      state_next = '0;
    end else if (store) begin
      state_next.frame_length = len_new;
      if (pos == 9'd4) begin
        state_next.key_byte = b;
      end
      if (pos == 9'd5) begin
        state_next.value_bytes_held[15:8] = b;
      end
      if (pos == 9'd6) begin
        state_next.value_bytes_held[7:0] = b;
      end
      // Sum all bytes before the checksum position, latch the checksum, then shift in the tail
      if ((pos < 9'd2) || (pos < {1'b0, len_new})) begin
        state_next.running_sum = state.running_sum + b;
      end else if (pos == {1'b0, len_new}) begin
        state_next.received_checksum = b;
      end else begin
        state_next.tail_bytes = {state.tail_bytes[7:0], b};
      end
      state_next.byte_count = pos + 9'd1;
    end
  end

  // Check the resulting state and form the result item
  always_comb begin
    eff_len_n  = (state_next.byte_count > 9'd2) ? {1'b0, state_next.frame_length} : 9'd0;
    complete_n = (state_next.byte_count == eff_len_n + OVERHEAD);
    key_ok_n   = (state_next.key_byte[7:6] == 2'b00) &&
                 key_mask[state_next.key_byte[5:0]];
    valid_n    = complete_n && (state_next.frame_length >= MIN_LENGTH) && key_ok_n &&
                 (state_next.running_sum == state_next.received_checksum) &&
                 (state_next.tail_bytes == {POST_FIRST, POST_SECOND});

    result                = '0;
    result.accepted       = store && (complete_n ? valid_n : 1'b1);
    result.frame_complete = complete_n;
    result.frame_valid    = valid_n;
    result.key_code       = state_next.key_byte;
    if (complete_n && (state_next.frame_length == LEN_ONE_VALUE)) begin
      result.value_word  = {8'h00, state_next.value_bytes_held[15:8]};
      result.value_bytes = 2'd1;
    end else if (complete_n && (state_next.frame_length == LEN_TWO_VALUE)) begin
      result.value_word  = state_next.value_bytes_held;
      result.value_bytes = 2'd2;
    end
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule
